// ----- rtl/pgls_pkg.sv -----
// package: request codes, register indexes, sequencer states and field widths
package pgls_pkg;

   localparam int DATA_W = 32;
   localparam int VAL_W  = 31;
   localparam int ROWI_W = 6;
   localparam int COLI_W = 5;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      REQ_LOAD_A = 2'd0,
      REQ_LOAD_B = 2'd1,
      REQ_LOAD_X = 2'd2,
      REQ_RUN    = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ITER  = 3'd0,
      CSR_RATE  = 3'd1,
      CSR_MAXST = 3'd2,
      CSR_ROWS  = 3'd3,
      CSR_COLS  = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ITER,
      ST_RES_MAC,
      ST_RES_DONE,
      ST_GRAD_MAC,
      ST_GRAD_MUL,
      ST_GRAD_UPD,
      ST_OUT_RD,
      ST_OUT_SEND
   } state_type;

   // operand select for the shared multiply-accumulate unit
   typedef struct packed {
      logic                     clear;
      logic                     enable;
      logic signed [DATA_W-1:0] op_a;
      logic signed [DATA_W-1:0] op_b;
   } mac_ctrl_type;

endpackage

// ----- rtl/pgls_if.sv -----
// valid/ready channel interfaces for request, response and register writes
interface pgls_req_if;
   import pgls_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               req_type;
   logic [ROWI_W-1:0]        row_index;
   logic [COLI_W-1:0]        col_index;
   logic signed [DATA_W-1:0] data_value;
   modport source (output valid, req_type, row_index, col_index, data_value, input ready);
   modport sink   (input valid, req_type, row_index, col_index, data_value, output ready);
endinterface

interface pgls_rsp_if;
   import pgls_pkg::*;
   logic              valid;
   logic              ready;
   logic [COLI_W-1:0] bin_index;
   logic [VAL_W-1:0]  bin_value;
   logic              last;
   modport source (output valid, bin_index, bin_value, last, input ready);
   modport sink   (input valid, bin_index, bin_value, last, output ready);
endinterface

interface pgls_csr_if;
   import pgls_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/projected_gradient_least_squares_unit.sv -----
// top level: load port, gradient descent sequencer and solution output
// Load transactions (matrix, target, solution entries) are taken one per cycle
// while no run is in progress. A run transaction holds req_ready low while one
// shared multiply-accumulate unit works through the data, fed one product per
// cycle through the single read port of the matrix memory; after the iterations
// each solution element is read in ST_OUT_RD and then presented on the
// response channel until taken. Memories have no reset; a run may only read
// entries that were loaded.
module projected_gradient_least_squares_unit #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 32
) (
   input  logic       clock,
   input  logic       reset,
   pgls_req_if.sink   req,
   pgls_rsp_if.source rsp,
   pgls_csr_if.sink   csr
);
   import pgls_pkg::*;

   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int AW = $clog2(MAX_ROWS*MAX_COLS);

   // configuration
   logic [15:0]      iter_cfg_ff;
   logic [VAL_W-1:0] rate_cfg_ff, maxst_cfg_ff;
   logic [6:0]       rows_cfg_ff;
   logic [5:0]       cols_cfg_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         iter_cfg_ff  <= 16'd100;
         rate_cfg_ff  <= 31'd16777;
         maxst_cfg_ff <= 31'd1678;
         rows_cfg_ff  <= 7'd64;
         cols_cfg_ff  <= 6'd32;
      end else if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_ITER:  iter_cfg_ff  <= csr.data[15:0];
            CSR_RATE:  rate_cfg_ff  <= csr.data[30:0];
            CSR_MAXST: maxst_cfg_ff <= csr.data[30:0];
            CSR_ROWS:  rows_cfg_ff  <= csr.data[6:0];
            CSR_COLS:  cols_cfg_ff  <= csr.data[5:0];
            default: ;
         endcase
      end
   end

   // effective counts, saturated to the memory sizes
   logic [RW:0] rows_eff;
   logic [CW:0] cols_eff;
   always_comb begin
      if ({25'd0, rows_cfg_ff} > MAX_ROWS) rows_eff = (RW+1)'(MAX_ROWS);
      else                                 rows_eff = (RW+1)'(rows_cfg_ff);
      if ({26'd0, cols_cfg_ff} > MAX_COLS) cols_eff = (CW+1)'(MAX_COLS);
      else                                 cols_eff = (CW+1)'(cols_cfg_ff);
   end

   // memories
   logic signed [DATA_W-1:0] a_mem [MAX_ROWS*MAX_COLS];
   logic signed [DATA_W-1:0] b_mem [MAX_ROWS];
   logic signed [DATA_W-1:0] x_mem [MAX_COLS];
   logic signed [DATA_W-1:0] r_mem [MAX_ROWS];
   logic signed [DATA_W-1:0] a_rd_ff, b_rd_ff, x_rd_ff, r_rd_ff;

   state_type state_ff, state_in;
   logic [15:0] it_ff, it_in;
   logic [RW:0] i_ff, i_in;
   logic [CW:0] j_ff, j_in;
   logic        rd_vld_ff, rd_vld_in;   // operands from the previous read are present
   logic signed [DATA_W-1:0] acc;
   mac_ctrl_type mac_ctrl;
   logic signed [63:0] step_ff, step_in;

   // read addresses
   logic [RW-1:0] rd_row;
   logic [CW-1:0] rd_col;
   logic          x_wr, r_wr;
   logic signed [DATA_W-1:0] x_wr_data, r_wr_data;
   logic [AW-1:0] a_wr_addr, a_rd_addr;

   logic req_fire;
   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;

   assign a_wr_addr = AW'(RW'(req.row_index) * MAX_COLS + CW'(req.col_index));
   assign a_rd_addr = AW'(rd_row * MAX_COLS + rd_col);

   always_ff @(posedge clock) begin
      if (req_fire && req.req_type == REQ_LOAD_A &&
          {26'd0, req.row_index} < MAX_ROWS && {27'd0, req.col_index} < MAX_COLS)
         a_mem[a_wr_addr] <= req.data_value;
      a_rd_ff <= a_mem[a_rd_addr];
   end
   always_ff @(posedge clock) begin
      if (req_fire && req.req_type == REQ_LOAD_B && {26'd0, req.row_index} < MAX_ROWS)
         b_mem[RW'(req.row_index)] <= req.data_value;
      b_rd_ff <= b_mem[rd_row];
   end
   always_ff @(posedge clock) begin
      if (req_fire && req.req_type == REQ_LOAD_X && {27'd0, req.col_index} < MAX_COLS)
         x_mem[CW'(req.col_index)] <= req.data_value;
      else if (x_wr)
         x_mem[rd_col] <= x_wr_data;
      x_rd_ff <= x_mem[rd_col];
   end
   always_ff @(posedge clock) begin
      if (r_wr) r_mem[rd_row] <= r_wr_data;
      r_rd_ff <= r_mem[rd_row];
   end

   pgls_mac u_mac (.clock(clock), .reset(reset), .ctrl(mac_ctrl), .acc(acc));

   // learning-rate product of the gradient, and clamp
   logic signed [63:0] lr_prod;
   logic signed [63:0] step_cl;
   logic signed [DATA_W:0] res_diff;
   logic signed [64:0] upd;
   logic [64:0]        upd_abs;
   logic [VAL_W-1:0]   out_val;
   logic [DATA_W:0]    x_abs;
   always_comb begin
      lr_prod = $signed({1'b0, rate_cfg_ff}) * acc;
      step_in = lr_prod >>> 24;
      if (step_ff > $signed({33'd0, maxst_cfg_ff}))       step_cl = {33'd0, maxst_cfg_ff};
      else if (step_ff < -$signed({33'd0, maxst_cfg_ff})) step_cl = -$signed({33'd0, maxst_cfg_ff});
      else                                                step_cl = step_ff;
      upd     = {{33{x_rd_ff[31]}}, x_rd_ff} - {step_cl[63], step_cl};
      upd_abs = upd[64] ? 65'(-upd) : 65'(upd);
      x_wr_data = (upd_abs > 65'h7FFFFFFF) ? 32'sh7FFFFFFF : upd_abs[31:0];
      res_diff  = {acc[31], acc} - {b_rd_ff[31], b_rd_ff};
      if (res_diff[32] != res_diff[31]) r_wr_data = res_diff[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      else                               r_wr_data = res_diff[31:0];
      x_abs   = x_rd_ff[31] ? (DATA_W+1)'(-{x_rd_ff[31], x_rd_ff}) : {1'b0, x_rd_ff};
      out_val = (x_abs > 33'h7FFFFFFF) ? 31'h7FFFFFFF : x_abs[30:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_fire && req.req_type == REQ_RUN) state_in = ST_ITER;
         ST_ITER:     if (cols_eff == '0) state_in = ST_IDLE;
                      else if (it_ff == iter_cfg_ff) state_in = ST_OUT_RD;
                      else if (rows_eff == '0) state_in = ST_GRAD_MAC;
                      else state_in = ST_RES_MAC;
         ST_RES_MAC:  if (rd_vld_ff && j_ff == cols_eff) state_in = ST_RES_DONE;
         ST_RES_DONE: if (i_ff + 1'b1 == rows_eff) state_in = ST_GRAD_MAC;
                      else state_in = ST_RES_MAC;
         ST_GRAD_MAC: if (rows_eff == '0 || (rd_vld_ff && i_ff == rows_eff))
                         state_in = ST_GRAD_MUL;
         ST_GRAD_MUL: state_in = ST_GRAD_UPD;
         ST_GRAD_UPD: if (j_ff + 1'b1 == cols_eff) state_in = ST_ITER;
                      else state_in = ST_GRAD_MAC;
         ST_OUT_RD:   state_in = ST_OUT_SEND;
         ST_OUT_SEND: if (rsp.ready) begin
                         if (j_ff + 1'b1 == cols_eff) state_in = ST_IDLE;
                         else state_in = ST_OUT_RD;
                      end
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs and counters
   always_comb begin
      it_in = it_ff;
      i_in  = i_ff;
      j_in  = j_ff;
      rd_vld_in = 1'b0;
      mac_ctrl = '{clear: 1'b0, enable: 1'b0, op_a: a_rd_ff, op_b: x_rd_ff};
      rd_row = i_ff[RW-1:0];
      rd_col = j_ff[CW-1:0];
      x_wr = 1'b0;
      r_wr = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            it_in = '0;
         end
         ST_ITER: begin
            i_in = '0;
            j_in = '0;
            mac_ctrl.clear = 1'b1;
         end
         ST_RES_MAC: begin
            // reads issued at j, product of the previous read accumulated
            mac_ctrl.enable = rd_vld_ff;
            if (j_ff != cols_eff) begin
               j_in = j_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
         end
         ST_RES_DONE: begin
            // b read of row i is present since the last read cycle
            r_wr = 1'b1;
            mac_ctrl.clear = 1'b1;
            j_in = '0;
            if (i_ff + 1'b1 == rows_eff) i_in = '0;
            else i_in = i_ff + 1'b1;
         end
         ST_GRAD_MAC: begin
            mac_ctrl.op_b = r_rd_ff;
            mac_ctrl.enable = rd_vld_ff;
            if (i_ff != rows_eff) begin
               i_in = i_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
         end
         ST_GRAD_MUL: begin
            // reread x_j for the update
         end
         ST_GRAD_UPD: begin
            x_wr = 1'b1;
            mac_ctrl.clear = 1'b1;
            i_in = '0;
            if (j_ff + 1'b1 == cols_eff) begin
               j_in = '0;
               it_in = it_ff + 1'b1;
            end else j_in = j_ff + 1'b1;
         end
         ST_OUT_RD: ;
         ST_OUT_SEND: begin
            if (rsp.ready) j_in = j_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         it_ff     <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         it_ff     <= it_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   assign rsp.valid     = (state_ff == ST_OUT_SEND);
   assign rsp.bin_index = COLI_W'(j_ff);
   assign rsp.bin_value = out_val;
   assign rsp.last      = (j_ff + 1'b1 == cols_eff);

endmodule

// ----- rtl/pgls_mac.sv -----
// shared multiply-accumulate unit: q8.24 product floored, saturated, added with saturation
module pgls_mac (
   input  logic                            clock,
   input  logic                            reset,
   input  pgls_pkg::mac_ctrl_type          ctrl,
   output logic signed [pgls_pkg::DATA_W-1:0] acc
);
   import pgls_pkg::*;

   logic signed [DATA_W-1:0]   acc_ff, acc_in;
   logic signed [2*DATA_W-1:0] prod;
   logic signed [39:0]         prod_sh;
   logic signed [DATA_W-1:0]   prod_sat;
   logic signed [DATA_W:0]     sum;

   always_comb begin
      prod    = ctrl.op_a * ctrl.op_b;
      // arithmetic shift is floor division by 2^24
      prod_sh = prod[63:24];
      if (prod_sh > 40'sh007FFFFFFF)       prod_sat = 32'sh7FFFFFFF;
      else if (prod_sh < -40'sh0080000000) prod_sat = 32'sh80000000;
      else                                 prod_sat = prod_sh[31:0];
      sum = {acc_ff[31], acc_ff} + {prod_sat[31], prod_sat};
      acc_in = acc_ff;
      if (ctrl.clear) acc_in = '0;
      else if (ctrl.enable) begin
         if (sum[32] != sum[31]) acc_in = sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
         else                    acc_in = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) acc_ff <= '0;
      else       acc_ff <= acc_in;
   end

   assign acc = acc_ff;
endmodule

// ----- rtl/pgls_checker.sv -----
// port-level checker for the solver, bound to the top level
module pgls_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_type,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_last
);
   import pgls_pkg::*;

   // no new request while a result waits
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken during output");
   // a held result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   // a load leaves the port ready
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type != REQ_RUN |=> req_ready)
      else $error("load stalled port");
   // a run makes the port busy
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_RUN |=> !req_ready)
      else $error("run not started");
   // final result returns to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready) else $error("no idle after last");
endmodule

bind projected_gradient_least_squares_unit pgls_checker u_pgls_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_type(req.req_type),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_last(rsp.last)
);

// ----- bench/tb_top.sv -----
// testbench for the projected gradient least squares unit with a scoreboard class
`timescale 1ns / 1ps

module tb_top;
   import pgls_pkg::*;

   typedef struct packed {
      logic [COLI_W-1:0] idx;
      logic [VAL_W-1:0]  val;
      logic              last;
   } solution_bin_type;

   class solution_scoreboard;
      int unsigned iter_cnt, rate, max_step, rows_cfg, cols_cfg;
      logic signed [DATA_W-1:0] a_mem [64*32];
      logic signed [DATA_W-1:0] b_mem [64];
      logic signed [DATA_W-1:0] x_mem [32];
      logic signed [DATA_W-1:0] r_mem [64];
      bit a_ok [64*32];
      bit b_ok [64];
      bit x_ok [32];
      solution_bin_type pending_bins [$];
      int errors;

      function new();
         iter_cnt = 100; rate = 16777; max_step = 1678; rows_cfg = 64; cols_cfg = 32;
         errors = 0;
      endfunction

      function int unsigned rows_eff();
         return rows_cfg > 64 ? 64 : rows_cfg;
      endfunction

      function int unsigned cols_eff();
         return cols_cfg > 32 ? 32 : cols_cfg;
      endfunction

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // arithmetic shift floors toward minus infinity
      function longint mac(longint acc, longint a, longint b);
         longint prod;
         prod = sat32((a * b) >>> 24);
         return sat32(acc + prod);
      endfunction

      function longint abs_sat(longint v);
         if (v < 0) v = -v;
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         return v;
      endfunction

      function void write_reg(csr_index_type idx, logic [DATA_W-1:0] d);
         case (idx)
            CSR_ITER:  iter_cnt = d[15:0];
            CSR_RATE:  rate     = d[30:0];
            CSR_MAXST: max_step = d[30:0];
            CSR_ROWS:  rows_cfg = d[6:0];
            CSR_COLS:  cols_cfg = d[5:0];
            default: ;
         endcase
      endfunction

      function void note_request(req_kind_type kind, int unsigned row, int unsigned col,
                                 logic signed [DATA_W-1:0] d);
         int unsigned rows, cols;
         longint acc, step;
         solution_bin_type bin;
         rows = rows_eff();
         cols = cols_eff();
         case (kind)
            REQ_LOAD_A: begin a_mem[row*32+col] = d; a_ok[row*32+col] = 1; end
            REQ_LOAD_B: begin b_mem[row] = d; b_ok[row] = 1; end
            REQ_LOAD_X: begin x_mem[col] = d; x_ok[col] = 1; end
            default: begin
               for (int unsigned it = 0; it < iter_cnt; it++) begin
                  for (int unsigned i = 0; i < rows; i++) begin
                     acc = 0;
                     for (int unsigned j = 0; j < cols; j++)
                        acc = mac(acc, a_mem[i*32+j], x_mem[j]);
                     r_mem[i] = DATA_W'(sat32(acc - longint'(b_mem[i])));
                  end
                  for (int unsigned j = 0; j < cols; j++) begin
                     acc = 0;
                     for (int unsigned i = 0; i < rows; i++)
                        acc = mac(acc, a_mem[i*32+j], r_mem[i]);
                     step = (longint'(rate) * acc) >>> 24;
                     if (step > longint'(max_step)) step = max_step;
                     if (step < -longint'(max_step)) step = -longint'(max_step);
                     x_mem[j] = DATA_W'(abs_sat(longint'(x_mem[j]) - step));
                  end
               end
               for (int unsigned j = 0; j < cols; j++) begin
                  bin.idx  = COLI_W'(j);
                  bin.val  = VAL_W'(abs_sat(longint'(x_mem[j])));
                  bin.last = (j + 1 == cols);
                  pending_bins.insert(pending_bins.size(), bin);
               end
            end
         endcase
      endfunction

      function void check_bin(solution_bin_type got);
         solution_bin_type exp_bin;
         if (pending_bins.size() == 0) begin
            $error("unexpected result transaction bin_index=%0d", got.idx);
            errors++;
            return;
         end
         exp_bin = pending_bins.pop_front();
         if (got.idx !== exp_bin.idx) begin
            $error("bin_index expected %0d actual %0d", exp_bin.idx, got.idx);
            errors++;
         end
         if (got.val !== exp_bin.val) begin
            $error("bin_value expected %0d actual %0d", exp_bin.val, got.val);
            errors++;
         end
         if (got.last !== exp_bin.last) begin
            $error("last expected %0d actual %0d", exp_bin.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   bit   quiet = 0;

   pgls_req_if req_ch();
   pgls_rsp_if rsp_ch();
   pgls_csr_if csr_ch();

   solution_scoreboard sb = new();

   projected_gradient_least_squares_unit DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr(csr_ch)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.req_type = REQ_LOAD_A;
      req_ch.row_index = 0;
      req_ch.col_index = 0;
      req_ch.data_value = 0;
      csr_ch.valid = 0;
      csr_ch.index = CSR_ITER;
      csr_ch.data = 0;
      rsp_ch.ready = 0;
   end

   function automatic int unsigned pick_gap();
      if (quiet) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [DATA_W-1:0] pick_data();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2, 3: return $urandom();
         default: return $signed($urandom_range(0, 32'h03ffffff)) - 32'sh01ffffff;
      endcase
   endfunction

   // response side: random stalls, checked at every accepting edge
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_bin('{idx: rsp_ch.bin_index, val: rsp_ch.bin_value, last: rsp_ch.last});
   end

   initial begin
      int unsigned n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_ch.ready <= 1;
         n = $urandom_range(1, 20);
         repeat (n) @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_ch.ready <= 0;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_req(req_kind_type kind, int unsigned row, int unsigned col,
                           logic [DATA_W-1:0] d);
      int unsigned gap;
      req_ch.valid      <= 1;
      req_ch.req_type   <= kind;
      req_ch.row_index  <= ROWI_W'(row);
      req_ch.col_index  <= COLI_W'(col);
      req_ch.data_value <= d;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(kind, row, col, d);
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // fill any entry the run would read that was never loaded
   task automatic start_run();
      for (int unsigned i = 0; i < sb.rows_eff(); i++) begin
         if (!sb.b_ok[i]) send_req(REQ_LOAD_B, i, $urandom_range(0, 31), pick_data());
         for (int unsigned j = 0; j < sb.cols_eff(); j++)
            if (!sb.a_ok[i*32+j]) send_req(REQ_LOAD_A, i, j, pick_data());
      end
      for (int unsigned j = 0; j < sb.cols_eff(); j++)
         if (!sb.x_ok[j]) send_req(REQ_LOAD_X, $urandom_range(0, 63), j, pick_data());
      send_req(REQ_RUN, $urandom_range(0, 63), $urandom_range(0, 31), $urandom());
   endtask

   task automatic wait_idle();
      req_ch.valid <= 0;
      @(posedge clock);
      while (sb.pending_bins.size() > 0) @(posedge clock);
      repeat (6) @(posedge clock);
      // a run with no columns still keeps the request side busy
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [DATA_W-1:0] d);
      csr_ch.valid <= 1;
      csr_ch.index <= idx;
      csr_ch.data  <= d;
      do @(posedge clock); while (!csr_ch.ready);
      sb.write_reg(idx, d);
      csr_ch.valid <= 0;
   endtask

   task automatic setup(int unsigned it, int unsigned lr, int unsigned ms,
                        int unsigned rows, int unsigned cols);
      wait_idle();
      write_reg(CSR_ITER, it);
      write_reg(CSR_RATE, lr);
      write_reg(CSR_MAXST, ms);
      write_reg(CSR_ROWS, rows);
      write_reg(CSR_COLS, cols);
   endtask

   task automatic random_items(int unsigned count);
      int unsigned r;
      for (int unsigned k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 14) start_run();
         else if (r < 60)
            send_req(REQ_LOAD_A, $urandom_range(0, 63), $urandom_range(0, 31), pick_data());
         else if (r < 75)
            send_req(REQ_LOAD_B, $urandom_range(0, 63), $urandom_range(0, 31), pick_data());
         else
            send_req(REQ_LOAD_X, $urandom_range(0, 63), $urandom_range(0, 31), pick_data());
      end
      start_run();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;

      // small problem, moderate rate
      setup(3, 16777, 1678, 4, 3);
      start_run();
      send_req(REQ_LOAD_X, 0, 0, 32'hff000000);
      start_run();
      // sender holds off until every result is back
      wait_idle();
      start_run();

      // zero iterations: negative and most negative solutions come back as magnitudes
      setup(0, 0, 0, 1, 1);
      send_req(REQ_LOAD_X, 63, 0, 32'h80000000);
      start_run();
      send_req(REQ_LOAD_X, 0, 0, 32'hfffffff0);
      start_run();

      // saturating accumulators and steps
      setup(2, 32'h7fffffff, 32'h7fffffff, 2, 2);
      send_req(REQ_LOAD_A, 0, 0, 32'h7fffffff);
      send_req(REQ_LOAD_A, 1, 1, 32'h80000000);
      send_req(REQ_LOAD_A, 0, 1, 32'h7fffffff);
      send_req(REQ_LOAD_A, 1, 0, 32'h80000000);
      send_req(REQ_LOAD_B, 0, 31, 32'h80000000);
      send_req(REQ_LOAD_B, 1, 31, 32'h7fffffff);
      send_req(REQ_LOAD_X, 0, 0, 32'h7fffffff);
      send_req(REQ_LOAD_X, 0, 1, 32'h80000000);
      start_run();

      // a column count above the maximum saturates to full width
      setup(1, 32'h01000000, 1000, 1, 63);
      start_run();

      // zero rows gives zero steps, zero columns gives no results
      setup(2, $urandom() >> 1, $urandom() >> 1, 0, 4);
      start_run();
      setup(3, 16777, 1678, 3, 0);
      start_run();
      start_run();

      // longest iteration count on the smallest problem
      setup(65535, 16777, 1678, 1, 1);
      start_run();

      for (int unsigned p = 0; p < 6; p++) begin
         setup($urandom_range(0, 6), $urandom() >> ($urandom_range(1, 16)),
               $urandom() >> ($urandom_range(1, 24)), $urandom_range(1, 4),
               $urandom_range(1, 4));
         quiet = (p == 2);
         random_items(11);
         quiet = 0;
      end

      req_ch.valid <= 0;
      while (sb.pending_bins.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #50000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ----- projected_gradient_least_squares_unit.f -----
rtl/pgls_pkg.sv
rtl/pgls_if.sv
rtl/pgls_mac.sv
rtl/projected_gradient_least_squares_unit.sv
rtl/pgls_checker.sv
bench/tb_top.sv
